// ===== rtl/dcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrf_pkg
// Types and constants shared by the disk controller register file: transfer
// payload structs, action codes, register selects and fixed read values.
// ----------------------------------------------------------------------------
package dcrf_pkg;

    // Action codes carried by an input transfer
    typedef enum logic [2:0] {
        ACT_HOST_RD  = 3'd0,
        ACT_HOST_WR  = 3'd1,
        ACT_MGMT_RD  = 3'd2,
        ACT_MGMT_WR  = 3'd3,
        ACT_BUS_INIT = 3'd4,
        ACT_INT_POLL = 3'd5
    } t_action;

    // Host register select (byte address bits 2:1)
    localparam logic [1:0] HREG_CS = 2'd0;
    localparam logic [1:0] HREG_BA = 2'd1;
    localparam logic [1:0] HREG_DA = 2'd2;
    localparam logic [1:0] HREG_MP = 2'd3;

    // Management word indexes
    localparam logic [2:0] MIDX_ID    = 3'd0;
    localparam logic [2:0] MIDX_CSBA  = 3'd1;
    localparam logic [2:0] MIDX_DAMP0 = 3'd2;
    localparam logic [2:0] MIDX_MP12  = 3'd3;
    localparam logic [2:0] MIDX_DRIVE = 3'd4;
    localparam logic [2:0] MIDX_CTRL  = 3'd5;

    // Fixed values
    localparam logic [31:0] ID_WORD      = 32'h524C_2002;
    localparam logic [31:0] BAD_INDEX    = 32'hDEAD_BEEF;
    localparam logic [7:0]  VECTOR_CODE  = 8'o160;
    localparam logic [17:0] BASE_ADDR    = 18'o774400;
    localparam logic [15:0] CS_RESET     = 16'o200;
    localparam logic [15:0] CS_ERR_MASK  = 16'o036000;
    localparam logic [15:0] CS_KEEP_MASK = 16'o037776;
    localparam logic [15:0] CS_INT_MASK  = 16'o300;
    localparam logic [2:0]  INT_LEVEL    = 3'd5;

    // Input transfer payload
    typedef struct packed {
        t_action     action;
        logic [2:0]  address;
        logic [31:0] write_data;
        logic        byte_mode;
        logic [2:0]  int_level;
    } t_in_item;

    // Result transfer payload
    typedef struct packed {
        logic [31:0] read_data;
        logic        accepted;
        logic [7:0]  int_vector;
    } t_out_item;

endpackage

// ===== rtl/disk_controller_register_file.sv =====
// ----------------------------------------------------------------------------
// disk_controller_register_file
// Host-bus and management register file of a cartridge disk controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one access:
//   host read or write, management read or write, bus init or interrupt
//   poll. Each access gives exactly one result on the output channel
//   (o_out_valid / i_out_stall / o_out_data): read data, an accepted flag
//   and an interrupt vector.
//   An access is first captured in the input register; the register file
//   update and the result register load then happen together on the edge
//   on which the result register advances. Throughput is one access per
//   cycle while the receiver does not stall, set by the single compute step between the two registers.
//   When the receiver stalls, the result register holds; the input
//   register holds its access and o_in_stall rises once it is occupied.
//   Reset (synchronous, active low) empties both registers, loads the
//   control/status register with 0200 octal, clears the other registers,
//   the drive bits and the host enable bit.
// ----------------------------------------------------------------------------
module disk_controller_register_file (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcrf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcrf_pkg::t_out_item o_out_data
);

    // Byte merge for host byte writes
    function automatic logic [15:0] put_byte(input logic [15:0] old,
                                             input logic [7:0] data,
                                             input logic hi);
        logic [15:0] res;
        if (hi) begin
            res = {data, old[7:0]};
        end else begin
            res = {old[15:8], data};
        end
        return res;
    endfunction

    // Pipeline registers
    logic                r_in_valid;
    dcrf_pkg::t_in_item  r_in_data;
    logic                r_out_valid;
    dcrf_pkg::t_out_item r_out_data;

    // Register file
    logic [15:0] r_cs, n_cs;
    logic [15:0] r_ba, n_ba;
    logic [15:0] r_da, n_da;
    logic [15:0] r_mp0, n_mp0;
    logic [15:0] r_mp1, n_mp1;
    logic [15:0] r_mp2, n_mp2;
    logic [3:0]  r_rdy, n_rdy;
    logic [3:0]  r_err, n_err;
    logic        r_en, n_en;

    dcrf_pkg::t_out_item n_result;
    logic                advance;
    logic [15:0]         cs_merged;
    logic [1:0]          drv_sel;
    logic                drv_rdy;
    logic                drv_err;
    logic                comp_err;
    logic [15:0]         host_wr;
    logic [15:0]         host_byte_base;
    logic [1:0]          host_reg;

    // Handshake
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status merge of the selected drive
    always_comb begin
        drv_sel   = r_cs[9:8];
        drv_rdy   = r_rdy[drv_sel];
        drv_err   = r_err[drv_sel];
        comp_err  = drv_err || ((r_cs & dcrf_pkg::CS_ERR_MASK) != 16'd0);
        cs_merged = (r_cs & dcrf_pkg::CS_KEEP_MASK)
                  | {comp_err, drv_err, 13'd0, drv_rdy};
    end

    // Host write value: word or byte merge into the addressed register
    always_comb begin
        host_reg = r_in_data.address[2:1];
        unique case (host_reg)
            dcrf_pkg::HREG_CS: host_byte_base = r_cs;
            dcrf_pkg::HREG_BA: host_byte_base = r_ba;
            dcrf_pkg::HREG_DA: host_byte_base = r_da;
            default:           host_byte_base = r_mp0;
        endcase
        if (r_in_data.byte_mode) begin
            host_wr = put_byte(host_byte_base, r_in_data.write_data[7:0],
                               r_in_data.address[0]);
        end else begin
            host_wr = r_in_data.write_data[15:0];
        end
    end

    // Access decode: next register state and result
    always_comb begin
        n_cs  = r_cs;
        n_ba  = r_ba;
        n_da  = r_da;
        n_mp0 = r_mp0;
        n_mp1 = r_mp1;
        n_mp2 = r_mp2;
        n_rdy = r_rdy;
        n_err = r_err;
        n_en  = r_en;
        n_result.read_data  = 32'd0;
        n_result.accepted   = 1'b1;
        n_result.int_vector = 8'd0;

        unique case (r_in_data.action)
            dcrf_pkg::ACT_HOST_RD: begin
                if (!r_en) begin
                    n_result.accepted = 1'b0;
                end else begin
                    unique case (host_reg)
                        dcrf_pkg::HREG_CS: begin
                            n_cs = cs_merged;
                            n_result.read_data = {16'd0, cs_merged};
                        end
                        dcrf_pkg::HREG_BA: n_result.read_data = {16'd0, r_ba};
                        dcrf_pkg::HREG_DA: n_result.read_data = {16'd0, r_da};
                        default: begin
                            // read first copy and rotate the ring
                            n_result.read_data = {16'd0, r_mp0};
                            n_mp0 = r_mp1;
                            n_mp1 = r_mp2;
                            n_mp2 = r_mp0;
                        end
                    endcase
                end
            end
            dcrf_pkg::ACT_HOST_WR: begin
                if (!r_en) begin
                    n_result.accepted = 1'b0;
                end else begin
                    unique case (host_reg)
                        dcrf_pkg::HREG_CS: n_cs = host_wr;
                        dcrf_pkg::HREG_BA: n_ba = host_wr;
                        dcrf_pkg::HREG_DA: n_da = host_wr;
                        default: begin
                            n_mp0 = host_wr;
                            n_mp1 = host_wr;
                            n_mp2 = host_wr;
                        end
                    endcase
                end
            end
            dcrf_pkg::ACT_MGMT_RD: begin
                n_cs = cs_merged;
                unique case (r_in_data.address)
                    dcrf_pkg::MIDX_ID:    n_result.read_data = dcrf_pkg::ID_WORD;
                    dcrf_pkg::MIDX_CSBA:  n_result.read_data = {r_ba, cs_merged};
                    dcrf_pkg::MIDX_DAMP0: n_result.read_data = {r_mp0, r_da};
                    dcrf_pkg::MIDX_MP12:  n_result.read_data = {r_mp2, r_mp1};
                    dcrf_pkg::MIDX_DRIVE: n_result.read_data = {24'd0, r_err, r_rdy};
                    dcrf_pkg::MIDX_CTRL:  n_result.read_data =
                        {r_en, 5'd0, dcrf_pkg::VECTOR_CODE, dcrf_pkg::BASE_ADDR};
                    default:              n_result.read_data = dcrf_pkg::BAD_INDEX;
                endcase
            end
            dcrf_pkg::ACT_MGMT_WR: begin
                unique case (r_in_data.address)
                    dcrf_pkg::MIDX_CSBA: begin
                        n_cs = r_in_data.write_data[15:0];
                        n_ba = r_in_data.write_data[31:16];
                    end
                    dcrf_pkg::MIDX_DAMP0: begin
                        n_da  = r_in_data.write_data[15:0];
                        n_mp0 = r_in_data.write_data[31:16];
                    end
                    dcrf_pkg::MIDX_MP12: begin
                        n_mp1 = r_in_data.write_data[15:0];
                        n_mp2 = r_in_data.write_data[31:16];
                    end
                    dcrf_pkg::MIDX_DRIVE: begin
                        n_rdy = r_in_data.write_data[3:0];
                        n_err = r_in_data.write_data[7:4];
                    end
                    dcrf_pkg::MIDX_CTRL: n_en = r_in_data.write_data[31];
                    default: ;
                endcase
            end
            dcrf_pkg::ACT_BUS_INIT: begin
                n_cs  = dcrf_pkg::CS_RESET;
                n_ba  = 16'd0;
                n_da  = 16'd0;
                n_mp0 = 16'd0;
                n_mp1 = 16'd0;
                n_mp2 = 16'd0;
            end
            dcrf_pkg::ACT_INT_POLL: begin
                if (r_in_data.int_level == dcrf_pkg::INT_LEVEL
                        && (r_cs & dcrf_pkg::CS_INT_MASK) == dcrf_pkg::CS_INT_MASK) begin
                    n_result.int_vector = dcrf_pkg::VECTOR_CODE;
                end
            end
            default: n_result.accepted = 1'b0;
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_result;
        end
    end

    // Register file update, once per access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs  <= dcrf_pkg::CS_RESET;
            r_ba  <= 16'd0;
            r_da  <= 16'd0;
            r_mp0 <= 16'd0;
            r_mp1 <= 16'd0;
            r_mp2 <= 16'd0;
            r_rdy <= 4'd0;
            r_err <= 4'd0;
            r_en  <= 1'b0;
        end else if (advance && r_in_valid) begin
            r_cs  <= n_cs;
            r_ba  <= n_ba;
            r_da  <= n_da;
            r_mp0 <= n_mp0;
            r_mp1 <= n_mp1;
            r_mp2 <= n_mp2;
            r_rdy <= n_rdy;
            r_err <= n_err;
            r_en  <= n_en;
        end
    end

endmodule
